// File: design/pdm_pkg.sv
`default_nettype none
package pdm_pkg;

   localparam logic [62:0] MAX63        = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] PERIOD_RESET = 63'd1000000;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_CYCLE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [62:0] wake;
      logic [62:0] finish;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_SEND
   } bk_state_type;

   function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? MAX63 : s[62:0];
   endfunction

endpackage
`default_nettype wire

// File: design/pdm_front.sv
`default_nettype none
module pdm_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [127:0]             req_tdata,
   input  wire                      req_tuser,
   input  pdm_pkg::fifo_stat_type   q_stat,
   output logic                     push,
   output pdm_pkg::item_type        push_item
);

   logic              valid_ff, valid_in;
   pdm_pkg::item_type item_ff;
   logic              take;

   assign req_tready = !valid_ff || !q_stat.full;
   assign take       = req_tvalid && req_tready;
   assign push       = valid_ff && !q_stat.full;
   assign push_item  = item_ff;
   assign valid_in   = take || (valid_ff && q_stat.full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // finish is ignored on a start beat; cleared so the back end sees a clean item
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.action <= req_tuser;
         item_ff.wake   <= req_tdata[62:0];
         item_ff.finish <= (req_tuser == pdm_pkg::ACT_CYCLE) ? req_tdata[125:63] : 63'd0;
      end
   end

endmodule
`default_nettype wire

// File: design/pdm_fifo.sv
`default_nettype none
module pdm_fifo (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  pdm_pkg::item_type        push_item,
   input  wire                      pop,
   output pdm_pkg::item_type        pop_item,
   output pdm_pkg::fifo_stat_type   stat
);

   pdm_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

// File: design/pdm_div.sv
`default_nettype none
module pdm_div (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire  [63:0]  dividend,
   input  wire  [63:0]  divisor,
   output logic         done,
   output logic [63:0]  quotient,
   output logic [63:0]  remainder
);

   // restoring divide, one quotient bit per cycle
   logic        busy_ff, done_ff;
   logic [5:0]  step_ff;
   logic [63:0] quo_ff, rem_ff, div_ff;
   logic [65:0] trial;
   logic        neg;

   assign trial     = {1'b0, rem_ff, quo_ff[63]} - {2'b00, div_ff};
   assign neg       = trial[65];
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 6'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= 64'd0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= neg ? {rem_ff[62:0], quo_ff[63]} : trial[63:0];
         quo_ff <= {quo_ff[62:0], ~neg};
      end
   end

endmodule
`default_nettype wire

// File: design/pdm_back.sv
`default_nettype none
module pdm_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire  [62:0]              period,
   input  pdm_pkg::fifo_stat_type   q_stat,
   input  pdm_pkg::item_type        q_item,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [575:0]             rsp_tdata
);

   pdm_pkg::bk_state_type state_ff, state_in;
   logic div_start, load_out, done_a, done_b;
   logic [63:0] quo_a, rem_a, quo_b, rem_b;

   logic [62:0] deadline_ff, planned_ff, late_ff, finish_ff;
   logic [63:0] cnt_ff, miss_ff;
   logic [62:0] min_ff, max_ff, sum_ff;
   logic        cycle_ff, fin_ge_ff;
   logic        rsp_valid_ff;
   logic [575:0] rsp_data_ff;

   // take-time arithmetic
   logic        is_cycle, fin_ge;
   logic [62:0] late, diff, sum_in;
   logic [63:0] cnt_in;

   assign is_cycle = (q_item.action == pdm_pkg::ACT_CYCLE);
   assign late     = (q_item.wake > deadline_ff) ? (q_item.wake - deadline_ff) : 63'd0;
   assign fin_ge   = (q_item.finish >= deadline_ff);
   assign diff     = fin_ge ? (q_item.finish - deadline_ff) : 63'd0;
   assign cnt_in   = cnt_ff + 64'd1;
   assign sum_in   = pdm_pkg::sat_add63(sum_ff, late);

   pdm_div u_div_miss (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  ({1'b0, diff}),
      .divisor   ({1'b0, period}),
      .done      (done_a),
      .quotient  (quo_a),
      .remainder (rem_a)
   );

   pdm_div u_div_mean (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  ({1'b0, sum_in}),
      .divisor   (cnt_in),
      .done      (done_b),
      .quotient  (quo_b),
      .remainder (rem_b)
   );

   // send-time arithmetic
   logic [62:0] missed, base, next_dl, mean;
   logic [63:0] miss_total;

   assign missed     = (cycle_ff && fin_ge_ff) ? quo_a[62:0] : 63'd0;
   assign base       = fin_ge_ff ? (finish_ff - rem_a[62:0]) : planned_ff;
   assign next_dl    = cycle_ff ? pdm_pkg::sat_add63(base, period) : deadline_ff;
   assign mean       = (cycle_ff && cnt_ff != 64'd0) ? quo_b[62:0] : 63'd0;
   assign miss_total = miss_ff + {1'b0, missed};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdm_pkg::BK_IDLE:
            if (!q_stat.empty) state_in = is_cycle ? pdm_pkg::BK_DIV : pdm_pkg::BK_SEND;
         pdm_pkg::BK_DIV:
            if (done_a && done_b) state_in = pdm_pkg::BK_SEND;
         pdm_pkg::BK_SEND:
            if (!rsp_valid_ff || rsp_tready) state_in = pdm_pkg::BK_IDLE;
         default: state_in = pdm_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         pdm_pkg::BK_IDLE: begin
            pop       = !q_stat.empty;
            div_start = !q_stat.empty && is_cycle;
         end
         pdm_pkg::BK_SEND: load_out = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdm_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         deadline_ff  <= 63'd0;
         cnt_ff       <= 64'd0;
         miss_ff      <= 64'd0;
         min_ff       <= 63'd0;
         max_ff       <= 63'd0;
         sum_ff       <= 63'd0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            miss_ff      <= miss_total;
            deadline_ff  <= next_dl;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            if (is_cycle) begin
               cnt_ff <= cnt_in;
               if (cnt_in == 64'd1 || late < min_ff) min_ff <= late;
               if (late > max_ff) max_ff <= late;
               sum_ff <= sum_in;
            end else begin
               cnt_ff      <= 64'd0;
               miss_ff     <= 64'd0;
               min_ff      <= 63'd0;
               max_ff      <= 63'd0;
               sum_ff      <= 63'd0;
               deadline_ff <= pdm_pkg::sat_add63(q_item.wake, period);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cycle_ff  <= is_cycle;
         fin_ge_ff <= fin_ge;
         finish_ff <= q_item.finish;
         late_ff   <= is_cycle ? late : 63'd0;
         planned_ff <= is_cycle ? deadline_ff : pdm_pkg::sat_add63(q_item.wake, period);
      end
      if (load_out) begin
         rsp_data_ff <= {7'd0, next_dl, mean, max_ff, min_ff, miss_total,
                         missed, late_ff, planned_ff, cnt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: design/periodic_deadline_monitor.sv
`default_nettype none
// channel  dir  handshake          payload
// req      in   req_tvalid/tready  tuser: action; tdata: wake_ns, finish_ns
// rsp      out  rsp_tvalid/tready  tdata: tick_sequence .. next_deadline_ns
// csr      in   csr_we             csr_wdata: period
//
// Cycle beat: the back end takes the item, runs 64-step restoring divides, then sends; the two
// dividers (miss count and mean) run side by side.
// Start beat: take then send in the back end, no divide.
// Front register plus a two-entry queue keep req flowing while the back end works.
// reset is synchronous, active high; the period returns to 1000000.
module periodic_deadline_monitor (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_tvalid,
   output logic          req_tready,
   input  wire  [127:0]  req_tdata,   // [62:0] wake_ns, [125:63] finish_ns, rest zero
   input  wire           req_tuser,   // [0] action
   output logic          rsp_tvalid,
   input  wire           rsp_tready,
   output logic [575:0]  rsp_tdata,   // tick_sequence, planned_deadline_ns, late_ns,
                                      // missed_now, miss_total, min_late_ns, max_late_ns,
                                      // mean_late_ns, next_deadline_ns, zero pad
   input  wire           csr_we,
   input  wire  [62:0]   csr_wdata
);

   logic [62:0] period_ff, period_eff;
   logic        push, pop;
   pdm_pkg::item_type      push_item, pop_item;
   pdm_pkg::fifo_stat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= pdm_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         period_ff <= csr_wdata;
      end
   end

   // zero period behaves as one
   assign period_eff = (period_ff == 63'd0) ? 63'd1 : period_ff;

   pdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   pdm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   pdm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .period     (period_eff),
      .q_stat     (q_stat),
      .q_item     (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("pop from empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full) else $error("push into full queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result valid after reset");

endmodule
`default_nettype wire
